### sv/utfd_pkg.sv
// Shared types and constants for the turbidity sensor frame decoder.
`default_nettype none
package utfd_pkg;

    localparam logic [7:0] CH_K  = 8'h4B;
    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [8:0] CH_ZERO = 9'd48;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [16:0] RECIP_NINE = 17'd116508;   // floor(2^20 / 9)
    localparam logic [31:0] RECIP_THOUSAND = 32'd2199023255;   // floor(2^41 / 1000)
    localparam logic signed [38:0] LIN_COEF   = 39'sd5742300;
    localparam logic [42:0]        QUAD_COEF  = 43'd11204;
    localparam logic signed [44:0] CONST_TERM = 45'sd435290000;
    localparam logic [9:0]         DIVISOR    = 10'd1000;

    typedef struct packed {
        logic              valid;
        logic signed [8:0] d3;
        logic signed [8:0] d5;
        logic signed [8:0] d6;
    } utfd_frame_t;

endpackage
`default_nettype wire

### sv/utfd_front.sv
// Byte classifier: tracks the ok mark, stored count and the three digit bytes.
`default_nettype none
module utfd_front
    import utfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        queue_full,
    output logic             push,
    output utfd_frame_t      frame
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

    logic              ok_reg, ok_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic signed [8:0] d3_reg, d3_next;
    logic signed [8:0] d5_reg, d5_next;
    logic signed [8:0] d6_reg, d6_next;
    logic              take;
    logic signed [8:0] digit;

    assign s_tready = !queue_full;
    assign take     = s_tvalid && s_tready;
    assign digit    = $signed({1'b0, s_tdata} - CH_ZERO);

    always_comb
    begin
        ok_next  = ok_reg;
        cnt_next = cnt_reg;
        d3_next  = d3_reg;
        d5_next  = d5_reg;
        d6_next  = d6_reg;
        push     = 1'b0;
        frame.valid = (cnt_reg != '0);
        frame.d3 = d3_reg;
        frame.d5 = d5_reg;
        frame.d6 = d6_reg;
        if (take)
        begin
            if (s_tdata == CH_K)
            begin
                ok_next = 1'b1;
            end
            else if (s_tdata == CH_CR || s_tdata == CH_O)
            begin
                ok_next = ok_reg;
            end
            else if (s_tdata == CH_LF)
            begin
                if (ok_reg)
                begin
                    push     = 1'b1;
                    ok_next  = 1'b0;
                    cnt_next = '0;
                    d3_next  = '0;
                    d5_next  = '0;
                    d6_next  = '0;
                end
            end
            else if (cnt_reg < DEPTH_C)
            begin
                if (cnt_reg == CW'(3))
                    d3_next = digit;
                if (cnt_reg == CW'(5))
                    d5_next = digit;
                if (cnt_reg == CW'(6))
                    d6_next = digit;
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg  <= 1'b0;
            cnt_reg <= '0;
            d3_reg  <= '0;
            d5_reg  <= '0;
            d6_reg  <= '0;
        end
        else
        begin
            ok_reg  <= ok_next;
            cnt_reg <= cnt_next;
            d3_reg  <= d3_next;
            d5_reg  <= d5_next;
            d6_reg  <= d6_next;
        end
    end

endmodule
`default_nettype wire

### sv/utfd_queue.sv
// Small queue of finished frame records between classifier and arithmetic.
`default_nettype none
module utfd_queue
    import utfd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire utfd_frame_t wr_frame,
    output logic       full,
    output logic       not_empty,
    input  wire logic  pop,
    output utfd_frame_t rd_frame
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    utfd_frame_t         mem [QUEUE_DEPTH];
    logic [PW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]         count_reg;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_frame  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wr_ptr_reg] <= wr_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop && not_empty)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if ((push && !full) && !(pop && not_empty))
                count_reg <= count_reg + (PW+1)'(1);
            else if (!(push && !full) && (pop && not_empty))
                count_reg <= count_reg - (PW+1)'(1);
        end
    end

endmodule
`default_nettype wire

### sv/utfd_back.sv
// Arithmetic sequencer: voltage, bar level and turbidity, then the output register.
`default_nettype none
module utfd_back
    import utfd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         frame_ready,
    input  wire utfd_frame_t  frame,
    output logic              pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,
    output logic [0:0]        m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQUARE, ST_POLY, ST_SUM, ST_RECIP, ST_REM, ST_FIX, ST_DONE
    } state_t;

    state_t             state_reg;
    logic               fvalid_reg;
    logic signed [15:0] volt_reg;
    logic               vneg_reg;
    logic [29:0]        vsq_reg;
    logic signed [38:0] lin_reg;
    logic [15:0]        mag2_reg;
    logic [33:0]        pct_prod_reg;
    logic [42:0]        quad_reg;
    logic signed [13:0] pct_reg;
    logic               nneg_reg;
    logic [42:0]        num_reg;
    logic [33:0]        q0_reg;
    logic [12:0]        rem_reg;
    logic [33:0]        quo_reg;
    logic               mvalid_reg;
    logic [63:0]        mdata_reg;
    logic               muser_reg;

    logic signed [15:0] d3x, d5x, d6x, volt_calc;
    logic signed [31:0] vw;
    logic [14:0]        vabs;
    logic [13:0]        q0;
    logic [16:0]        pct_rem;
    logic [13:0]        q_fix;
    logic signed [44:0] n_sum;
    logic [44:0]        n_mag;
    logic [63:0]        recip_prod;
    logic [42:0]        rem_full;
    logic [33:0]        turb34;
    logic [13:0]        bar14;
    logic               out_free;
    logic               out_load;

    // Whole thousands left in the remainder after the reciprocal estimate.
    function automatic logic [2:0] thousands(input logic [12:0] r);
        logic [2:0] t;
        t = '0;
        for (int k = 1; k < 8; k++)
            if (r >= 13'(k) * 13'(DIVISOR))
                t = 3'(k);
        return t;
    endfunction

    assign d3x = 16'(frame.d3);
    assign d5x = 16'(frame.d5);
    assign d6x = 16'(frame.d6);
    assign volt_calc = d3x * 16'sd100 + d5x * 16'sd10 + d6x;

    assign vw   = 32'(volt_reg);
    assign vabs = volt_reg[15] ? 15'(-volt_reg) : volt_reg[14:0];

    // The reciprocal product is never above the true quotient, so one step fixes it.
    assign q0      = pct_prod_reg[33:20];
    assign pct_rem = 17'(mag2_reg) - 17'(q0) * 17'd9;
    assign q_fix   = (pct_rem >= 17'd9) ? q0 + 14'd1 : q0;

    assign n_sum = 45'(lin_reg) - $signed(45'(quad_reg)) - CONST_TERM;
    assign n_mag = n_sum[44] ? 45'(-n_sum) : 45'(n_sum);

    // The estimate from the top 32 bits is at most seven short of the true quotient,
    // so the remainder stays below 8000 and a few compares finish the division.
    assign recip_prod = 64'(num_reg[42:11]) * 64'(RECIP_THOUSAND);
    assign rem_full   = num_reg - 43'(q0_reg) * 43'(DIVISOR);

    assign turb34 = nneg_reg ? (~quo_reg + 34'd1) : quo_reg;
    assign bar14  = 14'd100 - 14'(pct_reg);

    assign out_free = !mvalid_reg || m_tready;
    assign out_load = (state_reg == ST_DONE) && out_free;
    assign pop      = (state_reg == ST_IDLE) && frame_ready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fvalid_reg   <= 1'b0;
            volt_reg     <= '0;
            vneg_reg     <= 1'b0;
            vsq_reg      <= '0;
            lin_reg      <= '0;
            mag2_reg     <= '0;
            pct_prod_reg <= '0;
            quad_reg     <= '0;
            pct_reg      <= '0;
            nneg_reg     <= 1'b0;
            num_reg      <= '0;
            q0_reg       <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            mvalid_reg   <= 1'b0;
            mdata_reg    <= '0;
            muser_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
                mvalid_reg <= 1'b1;
            else if (m_tready)
                mvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (frame_ready)
                    begin
                        fvalid_reg <= frame.valid;
                        if (frame.valid)
                        begin
                            volt_reg  <= volt_calc;
                            state_reg <= ST_SQUARE;
                        end
                        else
                        begin
                            volt_reg  <= '0;
                            nneg_reg  <= 1'b0;
                            quo_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SQUARE:
                begin
                    vsq_reg      <= 30'(vw * vw);
                    lin_reg      <= 39'(volt_reg) * LIN_COEF;
                    vneg_reg     <= volt_reg[15];
                    mag2_reg     <= {vabs, 1'b0};
                    pct_prod_reg <= 34'({vabs, 1'b0}) * 34'(RECIP_NINE);
                    state_reg    <= ST_POLY;
                end
                ST_POLY:
                begin
                    quad_reg  <= 43'(vsq_reg) * QUAD_COEF;
                    pct_reg   <= vneg_reg ? $signed(-q_fix) : $signed(q_fix);
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    nneg_reg  <= n_sum[44];
                    num_reg   <= 43'(n_mag + 45'd500);
                    state_reg <= ST_RECIP;
                end
                ST_RECIP:
                begin
                    q0_reg    <= recip_prod[63:30];
                    state_reg <= ST_REM;
                end
                ST_REM:
                begin
                    rem_reg   <= rem_full[12:0];
                    state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    quo_reg   <= q0_reg + 34'(thousands(rem_reg));
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        muser_reg  <= fvalid_reg;
                        mdata_reg  <= {turb34, bar14, volt_reg};
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/uart_turbidity_frame_decoder_top.sv
// Top level of the turbidity sensor reply decoder.
// Reply bytes enter on the s_ stream one per transfer and are classified as each is
// accepted, so the byte stream runs at one byte per clock while the frame queue has
// room. Each LF that closes a frame hands a record to a two-entry queue; the arithmetic
// unit then steps through load, two multiply stages, sum, reciprocal multiply by
// 1/1000, remainder, correction and output for a frame with a reading, and through load
// and output for an empty frame. A stalled m_ side holds the arithmetic unit at its
// output step. Each frame end gives one m_ transfer: tuser flags a real reading or an
// empty frame, and tdata carries voltage, bar level and turbidity. The input stalls
// only while two frames wait.
`default_nettype none
module uart_turbidity_frame_decoder_top
    import utfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // voltage_centi[15:0], bar_level[29:16],
                                        // turbidity_centi[63:30]
    output logic [0:0]       m_tuser    // frame_valid[0]
);

    utfd_frame_t push_frame, head_frame;
    logic        push, pop, full, not_empty;

    utfd_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .queue_full(full),
        .push      (push),
        .frame     (push_frame)
    );

    utfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_frame (push_frame),
        .full     (full),
        .not_empty(not_empty),
        .pop      (pop),
        .rd_frame (head_frame)
    );

    utfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_ready(not_empty),
        .frame      (head_frame),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

### sv/utfd_checker.sv
// Port-level checks for the decoder, bound to the top level.
`default_nettype none
module utfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0 && m_tdata[63:30] == 34'd0)
        else $error("empty frame carries nonzero voltage or turbidity");

    a_volt_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            $signed(m_tdata[15:0]) >= -16'sd5328 && $signed(m_tdata[15:0]) <= 16'sd22977)
        else $error("voltage out of range");

    a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            $signed(m_tdata[29:16]) >= -14'sd5006 && $signed(m_tdata[29:16]) <= 14'sd1284)
        else $error("bar level out of range");

endmodule

bind uart_turbidity_frame_decoder_top utfd_checker u_utfd_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
`default_nettype wire
